### rtl/mlpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants of the multi-level priority FIFO
// Holds the payload structs, the controller states, status and action codes
// and the default sizes handed to the top level.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  localparam int LEVELS_DEF   = 16;
  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 16;

  localparam logic [3:0] TOP_LEVEL_RST = 4'd15;

  // Word index of the only configuration register.
  localparam logic REG_TOP_LEVEL = 1'b0;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_BADPRIO = 2'd3;

  typedef struct packed {
    logic        action;
    logic [15:0] item_id;
    logic [3:0]  item_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [3:0]  out_priority;
    logic [6:0]  waiting_total;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### rtl/multi_level_priority_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_level_priority_fifo_top: strict-priority queue of per-level FIFOs
// Levels are linked lists through one shared entry store with a free list;
// a row of level cells holds the list heads and finds the serving level.
// ----------------------------------------------------------------------------
// Each item passes the idle state and then the execute state: in the cycle of
// its transfer the level cells search for the serving level and the entry
// memories are read, and in the execute state the lists and memories are
// updated and the result is loaded into the output register. The item after
// it is taken while that result waits; a result not taken in time holds the block in its update cycle.
// No clearing pass follows reset: a fill count supplies the initial free
// chain, so items are taken from the first cycle after reset.
module multi_level_priority_fifo_top #(
  parameter int LEVELS   = mlpq_pkg::LEVELS_DEF,
  parameter int CAPACITY = mlpq_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = mlpq_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mlpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mlpq_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import mlpq_pkg::*;

  localparam int LW = $clog2(LEVELS);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t              state_r, state_nxt;
  logic [3:0]          top_level_r;
  logic [AW-1:0]       free_head_r, free_head_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic                act_r;
  logic [ID_BITS-1:0]  id_r;
  logic [LW-1:0]       lvl_r;
  logic [1:0]          stat_r;
  logic [AW-1:0]       addr_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                accept;
  logic                exec_done;
  logic [LW-1:0]       top_use;
  logic [LW-1:0]       lvl_c;
  logic [1:0]          stat_c;
  logic [AW-1:0]       addr_c;
  logic                upd_ok;
  logic                enq_ok;
  logic                deq_ok;
  logic [AW-1:0]       upd_entry;

  logic                found_w [LEVELS+1];
  logic [LW-1:0]       lvl_w   [LEVELS+1];
  logic [AW-1:0]       head_w  [LEVELS+1];
  logic [AW-1:0]       tail_a  [LEVELS];
  logic                busy_a  [LEVELS];

  logic [ID_BITS-1:0]  rd_id;
  logic [AW-1:0]       rd_next;
  logic                rd_fresh;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_level_r <= TOP_LEVEL_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOP_LEVEL)) begin
      top_level_r <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_TOP_LEVEL) ? {28'd0, top_level_r} : 32'd0;

  // A top level beyond the last cell acts as the last cell.
  assign top_use = (int'(top_level_r) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(top_level_r);

  // Level cells, searched from the highest index down.
  assign found_w[LEVELS] = 1'b0;
  assign lvl_w[LEVELS]   = '0;
  assign head_w[LEVELS]  = '0;

  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    mlpq_level_cell #(
      .LEVELS   (LEVELS),
      .CAPACITY (CAPACITY),
      .INDEX    (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .top_use   (top_use),
      .found_in  (found_w[k+1]),
      .lvl_in    (lvl_w[k+1]),
      .head_in   (head_w[k+1]),
      .found_out (found_w[k]),
      .lvl_out   (lvl_w[k]),
      .head_out  (head_w[k]),
      .upd_en    (upd_ok),
      .upd_enq   (act_r == ACT_ENQ),
      .upd_lvl   (lvl_r),
      .upd_entry (upd_entry),
      .tail      (tail_a[k]),
      .nonempty  (busy_a[k])
    );
  end

  // Decision at transfer time.
  always_comb begin
    if (in_data.action == ACT_ENQ) begin
      lvl_c  = LW'(in_data.item_priority);
      addr_c = free_head_r;
      if ((in_data.item_priority == 4'd0) || (int'(in_data.item_priority) > int'(top_use))) begin
        stat_c = STAT_BADPRIO;
      end else if (used_r >= CW'(CAPACITY)) begin
        stat_c = STAT_FULL;
      end else begin
        stat_c = STAT_OK;
      end
    end else begin
      lvl_c  = lvl_w[0];
      addr_c = head_w[0];
      stat_c = found_w[0] ? STAT_OK : STAT_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_data.action;
      id_r   <= ID_BITS'(in_data.item_id);
      lvl_r  <= lvl_c;
      stat_r <= stat_c;
      addr_r <= addr_c;
    end
  end

  // Controller
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    exec_done = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: exec_done = !out_valid_r || out_ready;
      default: begin
        in_ready  = 1'b0;
        exec_done = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Update cycle
  assign upd_ok    = exec_done && (stat_r == STAT_OK);
  assign enq_ok    = upd_ok && (act_r == ACT_ENQ);
  assign deq_ok    = upd_ok && (act_r == ACT_DEQ);
  assign upd_entry = (act_r == ACT_ENQ) ? addr_r : rd_next;

  always_comb begin
    free_head_nxt = free_head_r;
    used_nxt      = used_r;
    if (enq_ok) begin
      free_head_nxt = rd_next;
      used_nxt      = used_r + CW'(1);
    end else if (deq_ok) begin
      free_head_nxt = addr_r;
      used_nxt      = used_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      used_r      <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      used_r      <= used_nxt;
    end
  end

  mlpq_entry_store #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (addr_c),
    .rd_id    (rd_id),
    .rd_next  (rd_next),
    .rd_fresh (rd_fresh),
    .id_we    (enq_ok),
    .id_waddr (addr_r),
    .id_wdata (id_r),
    // An append links the old tail; a removal pushes the entry on the free list.
    .nx_we    (deq_ok || (enq_ok && busy_a[lvl_r])),
    .nx_waddr (deq_ok ? addr_r : tail_a[lvl_r]),
    .nx_wdata (deq_ok ? free_head_r : addr_r),
    .alloc    (enq_ok && rd_fresh)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_data_r.status        <= stat_r;
      out_data_r.out_id        <= deq_ok ? 16'(rd_id) : 16'd0;
      out_data_r.out_priority  <= deq_ok ? 4'(lvl_r) : 4'd0;
      out_data_r.waiting_total <= 7'(used_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/mlpq_level_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_level_cell: one priority level of the queue
// Holds head, tail and count of its level's linked list and takes part in
// the top-down search chain that picks the highest non-empty level.
// ----------------------------------------------------------------------------
module mlpq_level_cell #(
  parameter int LEVELS   = 16,
  parameter int CAPACITY = 64,
  parameter int INDEX    = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [$clog2(LEVELS)-1:0]   top_use,
  // search chain, from the level above
  input  logic                        found_in,
  input  logic [$clog2(LEVELS)-1:0]   lvl_in,
  input  logic [$clog2(CAPACITY)-1:0] head_in,
  // search chain, to the level below
  output logic                        found_out,
  output logic [$clog2(LEVELS)-1:0]   lvl_out,
  output logic [$clog2(CAPACITY)-1:0] head_out,
  // list update
  input  logic                        upd_en,
  input  logic                        upd_enq,
  input  logic [$clog2(LEVELS)-1:0]   upd_lvl,
  input  logic [$clog2(CAPACITY)-1:0] upd_entry,
  output logic [$clog2(CAPACITY)-1:0] tail,
  output logic                        nonempty
);

  import mlpq_pkg::*;

  localparam int LW = $clog2(LEVELS);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          enabled;
  logic          hit;

  assign enabled  = (INDEX != 0) && (LW'(INDEX) <= top_use);
  assign nonempty = (count_r != '0);
  assign tail     = tail_r;

  // The first enabled non-empty level met from the top claims the search.
  always_comb begin
    if (!found_in && enabled && nonempty) begin
      found_out = 1'b1;
      lvl_out   = LW'(INDEX);
      head_out  = head_r;
    end else begin
      found_out = found_in;
      lvl_out   = lvl_in;
      head_out  = head_in;
    end
  end

  assign hit = upd_en && (upd_lvl == LW'(INDEX));

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (hit) begin
      if (upd_enq) begin
        if (!nonempty) begin
          head_nxt = upd_entry;
        end
        tail_nxt  = upd_entry;
        count_nxt = count_r + CW'(1);
      end else begin
        count_nxt = count_r - CW'(1);
        if (count_r == CW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else begin
          head_nxt = upd_entry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/mlpq_entry_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_entry_store: shared entry memories of the queue
// Holds the id and the next link of every entry. A fill count stands in for
// the initial free chain: an entry never handed out links to its successor.
// ----------------------------------------------------------------------------
module mlpq_entry_store #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic [ID_BITS-1:0]          rd_id,
  output logic [$clog2(CAPACITY)-1:0] rd_next,
  output logic                        rd_fresh,
  input  logic                        id_we,
  input  logic [$clog2(CAPACITY)-1:0] id_waddr,
  input  logic [ID_BITS-1:0]          id_wdata,
  input  logic                        nx_we,
  input  logic [$clog2(CAPACITY)-1:0] nx_waddr,
  input  logic [$clog2(CAPACITY)-1:0] nx_wdata,
  input  logic                        alloc
);

  import mlpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ID_BITS-1:0] id_mem [CAPACITY];
  logic [AW-1:0]      nx_mem [CAPACITY];

  logic [ID_BITS-1:0] id_q_r;
  logic [AW-1:0]      nx_q_r;
  logic [AW-1:0]      succ_r;
  logic               fresh_hit_r;
  logic [CW-1:0]      fill_r, fill_nxt;

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_waddr] <= id_wdata;
    end
    if (rd_en) begin
      id_q_r <= id_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      nx_mem[nx_waddr] <= nx_wdata;
    end
    if (rd_en) begin
      nx_q_r <= nx_mem[rd_addr];
    end
  end

  // Entries at or above the fill count still hold their reset link.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fresh_hit_r <= (CW'(rd_addr) >= fill_r);
      succ_r      <= (rd_addr == AW'(CAPACITY - 1)) ? '0 : rd_addr + AW'(1);
    end
  end

  assign fill_nxt = alloc ? fill_r + CW'(1) : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign rd_id    = id_q_r;
  assign rd_next  = fresh_hit_r ? succ_r : nx_q_r;
  assign rd_fresh = fresh_hit_r;

endmodule

### bench/priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_queue_checker: result predictor and comparator
// Watches the item, result and register ports of the multi-level priority
// FIFO. It keeps its own copy of the per-level linked lists and the free
// list, works out the answer of every accepted item, and compares each
// accepted result, field by field, with the oldest answer still owed.
// ----------------------------------------------------------------------------
module priority_queue_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mlpq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mlpq_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  answers_owed
);

  import mlpq_pkg::*;

  localparam int LEVELS   = LEVELS_DEF;
  localparam int CAPACITY = CAPACITY_DEF;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam logic [2:0] TOP_LEVEL_ADDR = {REG_TOP_LEVEL, 2'b00};

  logic [3:0]       top_level;
  logic [IDX_W-1:0] level_first [LEVELS];
  logic [IDX_W-1:0] level_last  [LEVELS];
  logic [6:0]       level_fill  [LEVELS];
  logic [15:0]      slot_id     [CAPACITY];
  logic [IDX_W-1:0] slot_link   [CAPACITY];
  logic [IDX_W-1:0] free_first;
  logic [6:0]       held;
  out_item_t        queue_answers [$];
  int               errs = 0;

  task automatic clear_queue_model();
    top_level = TOP_LEVEL_RST;
    for (int l = 0; l < LEVELS; l++) begin
      level_first[l] = '0;
      level_last[l]  = '0;
      level_fill[l]  = '0;
    end
    // After reset the free list chains every slot to the next one.
    for (int s = 0; s < CAPACITY; s++) begin
      slot_id[s]   = '0;
      slot_link[s] = IDX_W'((s + 1) % CAPACITY);
    end
    free_first = '0;
    held       = '0;
  endtask

  task automatic apply_queue_op(input in_item_t op, output out_item_t ans);
    int top_eff;
    int lvl;
    logic [IDX_W-1:0] e;
    ans = '0;
    top_eff = (int'(top_level) > LEVELS - 1) ? LEVELS - 1 : int'(top_level);
    if (op.action == ACT_ENQ) begin
      // A bad level is reported ahead of a full store.
      if (op.item_priority == 4'd0 || int'(op.item_priority) > top_eff) begin
        ans.status = STAT_BADPRIO;
      end else if (int'(held) >= CAPACITY) begin
        ans.status = STAT_FULL;
      end else begin
        lvl = int'(op.item_priority);
        e = free_first;
        free_first = slot_link[e];
        slot_id[e] = op.item_id;
        if (level_fill[lvl] == 7'd0) begin
          level_first[lvl] = e;
        end else begin
          slot_link[level_last[lvl]] = e;
        end
        level_last[lvl] = e;
        level_fill[lvl] = level_fill[lvl] + 7'd1;
        held = held + 7'd1;
        ans.status = STAT_OK;
      end
    end else begin
      lvl = top_eff;
      while (lvl > 0 && level_fill[lvl] == 7'd0) lvl--;
      if (lvl == 0) begin
        ans.status = STAT_EMPTY;
      end else begin
        e = level_first[lvl];
        ans.out_id       = slot_id[e];
        ans.out_priority = 4'(lvl);
        level_first[lvl] = slot_link[e];
        level_fill[lvl]  = level_fill[lvl] - 7'd1;
        if (level_fill[lvl] == 7'd0) begin
          level_first[lvl] = '0;
          level_last[lvl]  = '0;
        end
        slot_link[e] = free_first;
        free_first   = e;
        held = held - 7'd1;
        ans.status = STAT_OK;
      end
    end
    ans.waiting_total = held;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t next_ans;
    if (!rst_n) begin
      clear_queue_model();
      queue_answers.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TOP_LEVEL_ADDR) begin
        top_level = pwdata[3:0];
      end
      // Results are checked before this edge's item is predicted, since a
      // result can never belong to an item taken at the same edge.
      if (out_valid && out_ready) begin
        if (queue_answers.size() == 0) begin
          errs++;
          $display("%0t: result with no item outstanding: expected none, ", $time,
                   "got status %0d id %h prio %0d held %0d",
                   out_data.status, out_data.out_id, out_data.out_priority,
                   out_data.waiting_total);
        end else begin
          want = queue_answers.pop_front();
          if (out_data.status !== want.status || out_data.out_id !== want.out_id ||
              out_data.out_priority !== want.out_priority ||
              out_data.waiting_total !== want.waiting_total) begin
            errs++;
            $display("%0t: mismatch: expected status %0d id %h prio %0d held %0d, ",
                     $time, want.status, want.out_id, want.out_priority,
                     want.waiting_total,
                     "got status %0d id %h prio %0d held %0d",
                     out_data.status, out_data.out_id, out_data.out_priority,
                     out_data.waiting_total);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_queue_op(in_data, next_ans);
        queue_answers.push_back(next_ans);
      end
    end
    fail_count   <= errs;
    answers_owed <= queue_answers.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench of the multi-level priority FIFO
// Drives directed and random enqueue and dequeue items through several
// top-level settings and idle patterns, including a long result stall that
// backs up the input. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import mlpq_pkg::*;

  localparam logic [2:0] TOP_LEVEL_ADDR = {REG_TOP_LEVEL, 2'b00};
  localparam int QUIET_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          answers_owed;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  logic [3:0]  cur_top = TOP_LEVEL_RST;

  multi_level_priority_fifo_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  priority_queue_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .answers_owed (answers_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("multi_level_priority_fifo_top regression: fail");
        $finish;
      end
    end
  end

  function automatic in_item_t mk(input logic act, input logic [15:0] id,
                                  input logic [3:0] prio);
    in_item_t it;
    it.action        = act;
    it.item_id       = id;
    it.item_priority = prio;
    return it;
  endfunction

  // Enqueues at the given percentage; an enqueue mostly takes a level in use, but about one in ten picks any level.
  function automatic in_item_t random_op(input int enq_pct, input logic [3:0] top);
    in_item_t it;
    it.item_id       = 16'($urandom);
    it.item_priority = 4'($urandom);
    if ($urandom_range(0, 99) < enq_pct) begin
      it.action = ACT_ENQ;
      if (top != 0 && $urandom_range(0, 9) != 0) begin
        it.item_priority = 4'($urandom_range(1, top));
      end
    end else begin
      it.action = ACT_DEQ;
    end
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every owed result has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_top_level(input logic [3:0] lvl);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOP_LEVEL_ADDR;
    pwdata  <= {28'd0, lvl};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_top = lvl;
  endtask

  // Long runs of enqueue-heavy and dequeue-heavy traffic sweep the fill
  // level from empty to a full store and back.
  task automatic run_phase(input logic [3:0] top, input int idle, input int stall,
                           input int count, input int hold);
    settle();
    write_top_level(top);
    idle_pct  = idle;
    stall_pct = stall;
    hold_left = hold;
    for (int i = 0; i < count; i++) begin
      offer(random_op(((i / 150) % 2 == 0) ? 85 : 20, cur_top));
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue, level zero, extremes of id and level, order within a level.
    offer(mk(ACT_DEQ, 16'h0000, 4'd0));
    offer(mk(ACT_ENQ, 16'h1111, 4'd0));
    offer(mk(ACT_ENQ, 16'hFFFF, 4'd15));
    offer(mk(ACT_ENQ, 16'h0000, 4'd1));
    offer(mk(ACT_ENQ, 16'h1234, 4'd1));
    offer(mk(ACT_ENQ, 16'hA5A5, 4'd7));
    offer(mk(ACT_DEQ, 16'hFFFF, 4'd15));
    offer(mk(ACT_DEQ, 16'h0000, 4'd0));
    offer(mk(ACT_DEQ, 16'h0000, 4'd0));
    offer(mk(ACT_DEQ, 16'h0000, 4'd0));
    offer(mk(ACT_DEQ, 16'h0000, 4'd0));
    offer(mk(ACT_ENQ, 16'h0F0F, 4'd12));

    // A lowered top level rejects higher levels and leaves their entries held.
    settle();
    write_top_level(4'd3);
    offer(mk(ACT_ENQ, 16'h4444, 4'd4));
    offer(mk(ACT_ENQ, 16'h5A5A, 4'd3));
    offer(mk(ACT_ENQ, 16'h7777, 4'd15));
    offer(mk(ACT_DEQ, 16'h0000, 4'd0));
    offer(mk(ACT_DEQ, 16'h0000, 4'd0));

    // Top level zero: every enqueue is rejected and every dequeue finds nothing.
    settle();
    write_top_level(4'd0);
    offer(mk(ACT_ENQ, 16'h8001, 4'd1));
    offer(mk(ACT_ENQ, 16'h8002, 4'd0));
    offer(mk(ACT_DEQ, 16'h0000, 4'd0));

    run_phase(4'd15, 0, 0, 300, 0);
    run_phase(4'd1, 64, 0, 250, 0);
    run_phase(4'd0, 0, 64, 80, 0);
    run_phase(4'd8, 27, 27, 300, 0);
    // The result side holds off while the input keeps offering items.
    run_phase(4'd15, 0, 0, 300, 400);
    run_phase(4'($urandom_range(2, 14)), 27, 27, 270, 0);

    settle();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && answers_owed == 0) begin
      $display("multi_level_priority_fifo_top regression: pass");
    end else begin
      $display("multi_level_priority_fifo_top regression: fail");
    end
    $finish;
  end

endmodule
